// ===== src/masked_sprite_blit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Masked sprite blit core - assertion macros
// Shared property wrappers for the sprite blit checker, clocked on aclk and
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_SPRITE_BLIT_CORE_MACROS_SVH
`define MASKED_SPRITE_BLIT_CORE_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define MSBLIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("masked sprite blit: same-cycle check failed");

// Next-cycle implication under the block clock and reset.
`define MSBLIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("masked sprite blit: next-cycle check failed");

`endif

// ===== src/msblit_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked sprite blit package
// Sizes, register indexes, reset values and the pipeline word type.
// ----------------------------------------------------------------------------
package msblit_pkg;

    localparam int ADDR_BITS  = 20;
    localparam int COORD_BITS = 10;
    localparam int DIM_BITS   = 8;

    localparam int COLOR_BITS = 16;
    localparam int MASK_BITS  = 8;
    // Mask bit for column 0 sits at the top of the mask byte.
    localparam logic [2:0] BIT_SEL = 3'd7;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEST_X        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEST_Y        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 3'd4;

    localparam logic [DIM_BITS-1:0]   SPRITE_WIDTH_RST  = DIM_BITS'(48);
    localparam logic [DIM_BITS-1:0]   SPRITE_HEIGHT_RST = DIM_BITS'(48);
    localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST   = COORD_BITS'(240);

    // Address arithmetic widths.
    localparam int ROWSUM_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
    localparam int PROD_BITS   = ROWSUM_BITS + COORD_BITS;
    localparam int FULL_BITS   = PROD_BITS + 1;
    localparam int CMP_BITS    = (FULL_BITS > ADDR_BITS) ? FULL_BITS : ADDR_BITS + 1;

    // Stream word widths, rounded up to whole bytes.
    localparam int S_TDATA_BITS = ((COLOR_BITS + MASK_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = ADDR_BITS + COLOR_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 8;

    // One pixel held between the input register and the result register.
    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        logic [MASK_BITS-1:0]  mask;
        logic [DIM_BITS-1:0]   col;
        logic [DIM_BITS-1:0]   row;
        logic                  last;
    } pix_item_t;

endpackage

// ===== src/masked_sprite_blit_core.sv =====
// ----------------------------------------------------------------------------
// Masked sprite blit core
// Turns a row-major stream of sprite pixels with their mask bytes into
// frame-buffer write requests, one request per pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)
//  --------  ---------  -------------------------------------------------------
//  s_        in         tdata: pixel_color[15:0], mask_byte[23:16]
//  m_        out        tdata: write_address[19:0], write_data[35:20], zero pad
//                       tuser: write_enable[0], out_of_range[1], zero pad
//                       tlast: last_pixel
//  cfg_      in         write-only register port, index per register list
//
//  Each word passes through the input register and then the result register,
//  and a new word can be accepted in every cycle while the output is not
//  stalled; throughput is one word per clock. The row-times-frame-width
//  multiply and the address add sit between the two registers.
//  s_tready follows the result register: it drops only while both stages are
//  full and m_tready is low, so a stall never loses or repeats a word.
//  aresetn is synchronous and active low; it empties both stages, returns the
//  pixel position to the top-left corner and loads the register defaults.
//
module masked_sprite_blit_core
    import msblit_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // Configuration write port.
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

    // Pixel input stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,   // pixel_color, mask_byte

    // Write request stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]  m_tdata,   // write_address, write_data
    output logic [M_TUSER_BITS-1:0]  m_tuser,   // write_enable, out_of_range
    output logic                     m_tlast    // last_pixel
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] dest_x_reg;
    logic [COORD_BITS-1:0] dest_y_reg;
    logic [DIM_BITS-1:0]   sprite_width_reg;
    logic [DIM_BITS-1:0]   sprite_height_reg;
    logic [COORD_BITS-1:0] frame_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg        <= '0;
            dest_y_reg        <= '0;
            sprite_width_reg  <= SPRITE_WIDTH_RST;
            sprite_height_reg <= SPRITE_HEIGHT_RST;
            frame_width_reg   <= FRAME_WIDTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DEST_X:        dest_x_reg        <= cfg_wdata[COORD_BITS-1:0];
                REG_DEST_Y:        dest_y_reg        <= cfg_wdata[COORD_BITS-1:0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_wdata[DIM_BITS-1:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_wdata[DIM_BITS-1:0];
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[COORD_BITS-1:0];
                default: ;  // Indexes past the register list are ignored.
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // The result register can load when it is empty or its word is being
    // taken; the input register can load when it is empty or moving on.
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       out_load;
    logic       in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Pixel position counters
    // ------------------------------------------------------------------
    // A width or height of zero stands for the full counter range. A counter
    // at or beyond the last column or row counts as being on it, so a size
    // change in the middle of a sprite still wraps cleanly.
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS:0]   eff_width;
    logic [DIM_BITS:0]   eff_height;
    logic                col_last;
    logic                row_last;

    assign eff_width  = (sprite_width_reg == '0)  ? ((DIM_BITS+1)'(1) << DIM_BITS)
                                                  : {1'b0, sprite_width_reg};
    assign eff_height = (sprite_height_reg == '0) ? ((DIM_BITS+1)'(1) << DIM_BITS)
                                                  : {1'b0, sprite_height_reg};
    assign col_last = ({1'b0, col_reg} + (DIM_BITS+1)'(1)) >= eff_width;
    assign row_last = ({1'b0, row_reg} + (DIM_BITS+1)'(1)) >= eff_height;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_load) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + DIM_BITS'(1);
            end else begin
                col_next = col_reg + DIM_BITS'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register: the pixel together with its position
    // ------------------------------------------------------------------
    pix_item_t in_item_reg;
    pix_item_t in_item_next;

    always_comb begin
        in_item_next.color = s_tdata[COLOR_BITS-1:0];
        in_item_next.mask  = s_tdata[COLOR_BITS +: MASK_BITS];
        in_item_next.col   = col_reg;
        in_item_next.row   = row_reg;
        in_item_next.last  = col_last && row_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= in_item_next;
        end
    end

    // ------------------------------------------------------------------
    // Address and mask evaluation
    // ------------------------------------------------------------------
    // address = (dest_y + row) * frame_width + dest_x + col. Anything that
    // does not fit in the address width suppresses the write and reads as
    // address zero.
    logic [ROWSUM_BITS-1:0] row_sum;
    logic [ROWSUM_BITS-1:0] col_sum;
    logic [PROD_BITS-1:0]   row_base;
    logic [CMP_BITS-1:0]    full_addr;
    logic                   addr_oor;
    logic                   mask_bit;
    logic [ADDR_BITS-1:0]   addr_out;

    assign row_sum   = ROWSUM_BITS'(dest_y_reg) + ROWSUM_BITS'(in_item_reg.row);
    assign col_sum   = ROWSUM_BITS'(dest_x_reg) + ROWSUM_BITS'(in_item_reg.col);
    assign row_base  = PROD_BITS'(row_sum) * PROD_BITS'(frame_width_reg);
    assign full_addr = CMP_BITS'(row_base) + CMP_BITS'(col_sum);
    assign addr_oor  = full_addr >= (CMP_BITS'(1) << ADDR_BITS);
    assign addr_out  = addr_oor ? '0 : full_addr[ADDR_BITS-1:0];
    // Column 0 of each group of eight takes the top bit of the mask byte.
    assign mask_bit  = in_item_reg.mask[BIT_SEL - in_item_reg.col[2:0]];

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [M_TDATA_BITS-1:0] out_data_reg;
    logic [M_TUSER_BITS-1:0] out_user_reg;
    logic                    out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_data_reg <= M_TDATA_BITS'({in_item_reg.color, addr_out});
            out_user_reg <= M_TUSER_BITS'({addr_oor, mask_bit && !addr_oor});
            out_last_reg <= in_item_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/msblit_checker.sv =====
// ----------------------------------------------------------------------------
// Masked sprite blit checker
// Port-level checks on the write request stream, bound to the core.
// ----------------------------------------------------------------------------
`include "masked_sprite_blit_core_macros.svh"

module msblit_checker
    import msblit_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_BITS-1:0]  m_tdata,
    input logic [M_TUSER_BITS-1:0]  m_tuser,
    input logic                     m_tlast
);

    // A stalled request keeps its whole word.
    `MSBLIT_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // An address that does not fit never produces a write.
    `MSBLIT_ASSERT_NOW(a_oor_no_write, m_tvalid && m_tuser[1], !m_tuser[0])

    // An out-of-range request carries address zero.
    `MSBLIT_ASSERT_NOW(a_oor_zero_addr, m_tvalid && m_tuser[1], m_tdata[ADDR_BITS-1:0] == '0)

    // With the output side free, the input side is never held off.
    `MSBLIT_ASSERT_NOW(a_ready_when_free, !m_tvalid || m_tready, s_tready)

endmodule

bind masked_sprite_blit_core msblit_checker u_msblit_checker (.*);

// ===== test/tb_masked_sprite_blit_core.sv =====
// ----------------------------------------------------------------------------
// Masked sprite blit core - testbench
// Streams sprite pixels with mask bytes into the core and checks every write
// request against an in-bench model of the pixel counters, the mask bit
// selection and the frame-buffer address arithmetic. Opens with a table of
// directed words, then runs randomized phases under several idling patterns.
// ----------------------------------------------------------------------------
module tb_masked_sprite_blit_core;
    import msblit_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_PIXELS   = 130;
    localparam int REPORT_LIMIT   = 10;

    // One write request as it leaves the core.
    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  addr;
        logic [COLOR_BITS-1:0] data;
        logic                  last;
        logic                  oor;
    } write_req_t;

    typedef enum logic [0:0] {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    // A row of the directed table is either a register write or a pixel word.
    // A pixel row may carry a hand-written expected request; if not, the
    // model below supplies it.
    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0] value;
        logic [COLOR_BITS-1:0]    color;
        logic [MASK_BITS-1:0]     mask;
        logic                     fixed;
        write_req_t               res;
    } stim_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;

    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [M_TUSER_BITS-1:0] m_tuser;
    logic                    m_tlast;

    // Hand-written expectation that travels alongside the word on s_tdata.
    logic       pin_fixed     = 1'b0;
    write_req_t pin_fixed_res = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_count    = 0;
    int cycle_count  = 0;

    // Shadow copies of the configuration registers and the pixel position.
    logic [COORD_BITS-1:0] dst_x, dst_y, frame_w;
    logic [DIM_BITS-1:0]   spr_w, spr_h;
    logic [DIM_BITS-1:0]   col_pos, row_pos;

    // Requests still owed by the core, oldest first.
    write_req_t write_req_q[$];

    // Directed words. After reset the sprite is 48 by 48 at the origin of a
    // 240-pixel frame. The table walks the mask bit order, shrinks the
    // sprite while the counters sit mid-row, runs the address to its top
    // and past it, drops the frame width to zero and finally selects the
    // full 256 by 256 sprite through a zero size (upper write bits set on the width).
    stim_row_t directed_tbl [DIRECTED_ROWS] = '{
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'hFFFF, 8'h80, 1'b1,
          '{1'b1, 20'h00000, 16'hFFFF, 1'b0, 1'b0}},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h0000, 8'h7F, 1'b1,
          '{1'b1, 20'h00001, 16'h0000, 1'b0, 1'b0}},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h8001, 8'hDF, 1'b0, '0},
        '{ROW_WRITE, REG_SPRITE_WIDTH,  10'h001, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_SPRITE_HEIGHT, 10'h001, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h5A5A, 8'h00, 1'b1,
          '{1'b0, 20'h00003, 16'h5A5A, 1'b1, 1'b0}},
        '{ROW_WRITE, REG_DEST_X,        10'h3FF, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_DEST_Y,        10'h3FF, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_FRAME_WIDTH,   10'h3FF, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_SPRITE_WIDTH,  10'h002, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_SPRITE_HEIGHT, 10'h002, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h1234, 8'hFF, 1'b1,
          '{1'b1, 20'hFFC00, 16'h1234, 1'b0, 1'b0}},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h4321, 8'hFF, 1'b1,
          '{1'b1, 20'hFFC01, 16'h4321, 1'b0, 1'b0}},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'hFFFF, 8'hFF, 1'b1,
          '{1'b1, 20'hFFFFF, 16'hFFFF, 1'b0, 1'b0}},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h0001, 8'hFF, 1'b1,
          '{1'b0, 20'h00000, 16'h0001, 1'b1, 1'b1}},
        '{ROW_WRITE, REG_FRAME_WIDTH,   10'h000, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'hAAAA, 8'h00, 1'b0, '0},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h5555, 8'h40, 1'b0, '0},
        '{ROW_WRITE, REG_SPRITE_WIDTH,  10'h300, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_SPRITE_HEIGHT, 10'h000, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_DEST_X,        10'h000, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_DEST_Y,        10'h000, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_WRITE, REG_FRAME_WIDTH,   10'h001, 16'h0000, 8'h00, 1'b0, '0},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'h0F0F, 8'h01, 1'b0, '0},
        '{ROW_PIXEL, REG_DEST_X,        10'h000, 16'hF0F0, 8'hFE, 1'b0, '0}
    };

    masked_sprite_blit_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // pixel_color, mask_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // write_address, write_data
        .m_tuser   (m_tuser),     // write_enable, out_of_range
        .m_tlast   (m_tlast)      // last_pixel
    );

    always #5 aclk = ~aclk;

    // Computes the request for one pixel at the current position and then
    // steps the column and row counters.
    function automatic write_req_t next_write_request(input logic [COLOR_BITS-1:0] color,
                                                      input logic [MASK_BITS-1:0]  mask);
        logic [DIM_BITS:0] w_eff, h_eff;
        logic [63:0]       addr;
        logic              col_end, row_end;
        write_req_t        r;
        // A zero size means the full counter range: the extra top bit is set.
        w_eff = {spr_w == '0, spr_w};
        h_eff = {spr_h == '0, spr_h};
        addr = (64'(dst_y) + 64'(row_pos)) * 64'(frame_w) + 64'(dst_x) + 64'(col_pos);
        r.oor  = addr >= (64'd1 << ADDR_BITS);
        r.we   = mask[BIT_SEL - col_pos[2:0]] && !r.oor;
        r.addr = r.oor ? '0 : addr[ADDR_BITS-1:0];
        r.data = color;
        // Being at or past the last column or row counts as being on it, so a
        // size shrunk under a running sprite wraps on the next word.
        col_end = ({1'b0, col_pos} + 1'b1) >= w_eff;
        row_end = ({1'b0, row_pos} + 1'b1) >= h_eff;
        r.last = col_end && row_end;
        if (col_end) begin
            col_pos = '0;
            row_pos = row_end ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        return r;
    endfunction

    // Picks a coordinate or a frame width, favoring the ends of the range.
    function automatic logic [CFG_DATA_BITS-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {COORD_BITS{1'b1}};
            2: return CFG_DATA_BITS'(1);
            default: return CFG_DATA_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    // Picks a sprite size, mostly small so that sprites finish often. Bits
    // above the register width are random and must be dropped by the core.
    function automatic logic [CFG_DATA_BITS-1:0] pick_dim();
        logic [CFG_DATA_BITS-1:0] v;
        v = CFG_DATA_BITS'($urandom);
        case ($urandom_range(0, 9))
            0: v[DIM_BITS-1:0] = '0;
            1: v[DIM_BITS-1:0] = {DIM_BITS{1'b1}};
            2: v[DIM_BITS-1:0] = DIM_BITS'(1);
            default: v[DIM_BITS-1:0] = DIM_BITS'($urandom_range(1, 12));
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Offers one pixel word, after an optional random idle gap, and returns
    // in the time step of the edge that accepts it.
    task automatic send_pixel(input logic [COLOR_BITS-1:0] color,
                              input logic [MASK_BITS-1:0]  mask,
                              input logic                  fixed,
                              input write_req_t            res);
        cfg_wr_en <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= S_TDATA_BITS'({mask, color});
        pin_fixed     <= fixed;
        pin_fixed_res <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops the sender and waits until every owed request has come out, then
    // idles on past that to cover the two-stage pipeline.
    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        while (write_req_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side: a random stall pattern set per phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Tracks register writes, predicts a request for each accepted pixel
    // word and checks each accepted request against the oldest prediction.
    always @(posedge aclk) begin
        write_req_t want, got;
        if (!aresetn) begin
            dst_x   = '0;
            dst_y   = '0;
            spr_w   = SPRITE_WIDTH_RST;
            spr_h   = SPRITE_HEIGHT_RST;
            frame_w = FRAME_WIDTH_RST;
            col_pos = '0;
            row_pos = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DEST_X:        dst_x   = cfg_wdata[COORD_BITS-1:0];
                    REG_DEST_Y:        dst_y   = cfg_wdata[COORD_BITS-1:0];
                    REG_SPRITE_WIDTH:  spr_w   = cfg_wdata[DIM_BITS-1:0];
                    REG_SPRITE_HEIGHT: spr_h   = cfg_wdata[DIM_BITS-1:0];
                    REG_FRAME_WIDTH:   frame_w = cfg_wdata[COORD_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                // The model always runs so that its counters keep pace, even
                // when the table supplies the expected request by hand.
                want = next_write_request(s_tdata[COLOR_BITS-1:0],
                                          s_tdata[COLOR_BITS +: MASK_BITS]);
                if (pin_fixed)
                    want = pin_fixed_res;
                write_req_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.we   = m_tuser[0];
                got.oor  = m_tuser[1];
                got.addr = m_tdata[ADDR_BITS-1:0];
                got.data = m_tdata[ADDR_BITS +: COLOR_BITS];
                got.last = m_tlast;
                if (write_req_q.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("unexpected request: we=%0b addr=%05h data=%04h last=%0b oor=%0b",
                                 got.we, got.addr, got.data, got.last, got.oor);
                end else begin
                    want = write_req_q.pop_front();
                    if (got.we !== want.we || got.addr !== want.addr
                            || got.data !== want.data || got.last !== want.last
                            || got.oor !== want.oor) begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT) begin
                            $write("request mismatch: expected we=%0b addr=%05h data=%04h ",
                                   want.we, want.addr, want.data);
                            $write("last=%0b oor=%0b, got we=%0b addr=%05h data=%04h ",
                                   want.last, want.oor, got.we, got.addr, got.data);
                            $display("last=%0b oor=%0b", got.last, got.oor);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int ph, n;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. Registers are only written with the core drained.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_tbl[i].kind == ROW_WRITE) begin
                if (i == 0 || directed_tbl[i-1].kind == ROW_PIXEL)
                    settle();
                write_reg(directed_tbl[i].reg_idx, directed_tbl[i].value);
            end else begin
                send_pixel(directed_tbl[i].color, directed_tbl[i].mask,
                           directed_tbl[i].fixed, directed_tbl[i].res);
            end
        end

        // Random phases. Each one drains the core, loads a fresh setting into
        // every register (leaving the counters wherever the last phase left
        // them) and streams random pixels under one idling pattern: none,
        // a mostly idle sender, a mostly stalled receiver, or both lightly.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            if (ph % 3 == 2) begin
                // Far corner of a wide frame: many addresses run past the top.
                write_reg(REG_DEST_X, CFG_DATA_BITS'($urandom_range(900, 1023)));
                write_reg(REG_DEST_Y, CFG_DATA_BITS'($urandom_range(900, 1023)));
                write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'($urandom_range(900, 1023)));
            end else begin
                write_reg(REG_DEST_X, pick_coord());
                write_reg(REG_DEST_Y, pick_coord());
                write_reg(REG_FRAME_WIDTH, pick_coord());
            end
            write_reg(REG_SPRITE_WIDTH, pick_dim());
            write_reg(REG_SPRITE_HEIGHT, pick_dim());
            for (n = 0; n < PHASE_PIXELS; n++) begin
                // Once in the run the sender holds off until the core is empty.
                if (ph == 5 && n == PHASE_PIXELS / 2)
                    settle();
                send_pixel(COLOR_BITS'($urandom), MASK_BITS'($urandom), 1'b0, '0);
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/msblit_pkg.sv
src/masked_sprite_blit_core.sv
src/msblit_checker.sv
test/tb_masked_sprite_blit_core.sv
